/* design/fwt_pkg.sv */
// ----------------------------------------------------------------------------
// fwt_pkg
// Shared types and constants of the fixed length word trie: request field
// layout, response width and command codes.
// ----------------------------------------------------------------------------
package fwt_pkg;

   localparam int LETTER_W      = 5;
   localparam int LETTER_FIELDS = 5;
   localparam int REQ_DATA_W    = 32;
   localparam int RSP_DATA_W    = 8;

   typedef enum logic {
      CMD_LOOKUP = 1'b0,
      CMD_INSERT = 1'b1
   } cmd_type;

endpackage

/* design/fixed_length_word_trie.sv */
// ----------------------------------------------------------------------------
// fixed_length_word_trie
// Dictionary of fixed length words kept as a trie in one link memory,
// with insert and lookup requests.
// ----------------------------------------------------------------------------
// req channel: one request per word, tuser holds the command (lookup or
// insert), tdata the five letter codes; codes past the alphabet saturate.
// rsp channel: one response per request with present and pool_exhausted.
// One request is in flight at a time. Each trie level walked passes
// through S_ISSUE (address into the link memory) and then S_CHECK (the
// registered read data); an insert then writes its new links in S_WRITE
// after the walk. req_tready rises again in the same cycle as response
// valid. A response waits in its register while rsp_tready is low; the
// next request is taken once that response has been loaded.
// After reset all NODE_COUNT * ALPHABET_SIZE link memory entries (425984
// at the defaults) are swept to zero, one entry a cycle; req_tready stays
// low during the sweep.
// ----------------------------------------------------------------------------
module fixed_length_word_trie
   import fwt_pkg::*;
#(
   parameter int NODE_COUNT    = 16384,
   parameter int WORD_LENGTH   = 5,
   parameter int ALPHABET_SIZE = 26
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [4:0] letter_first, [9:5] letter_second, [14:10] letter_third,
   // [19:15] letter_fourth, [24:20] letter_fifth, [31:25] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // [0] cmd
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [0] present, [1] pool_exhausted, [7:2] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int DEPTH  = NODE_COUNT * ALPHABET_SIZE;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int FREE_W = $clog2(NODE_COUNT + 1);
   localparam int LVL_W  = $clog2(WORD_LENGTH);
   localparam logic [LVL_W-1:0]    LAST_LVL = LVL_W'(WORD_LENGTH - 1);
   localparam logic [NODE_W-1:0]   END_MARK = NODE_W'(1);
   localparam logic [ADDR_W-1:0]   ALPHA_A  = ADDR_W'(ALPHABET_SIZE);
   localparam logic [ADDR_W-1:0]   CLR_LAST = ADDR_W'(DEPTH - 1);
   localparam logic [LETTER_W:0]   ALPHA_L  = (LETTER_W + 1)'(ALPHABET_SIZE);
   localparam logic [LETTER_W-1:0] SAT_CODE = LETTER_W'(ALPHABET_SIZE - 1);
   localparam logic [FREE_W:0]     POOL_TOP = (FREE_W + 1)'(NODE_COUNT);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ISSUE,
      S_CHECK,
      S_WRITE,
      S_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [ADDR_W-1:0]   clr_ff, clr_in;
   logic [FREE_W-1:0]   free_ff, free_in;
   logic [NODE_W-1:0]   node_ff, node_in;
   logic [LVL_W-1:0]    level_ff, level_in;
   cmd_type             cmd_ff, cmd_in;
   logic [LETTER_W-1:0] letters_ff [WORD_LENGTH];
   logic [LETTER_W-1:0] letters_in [WORD_LENGTH];
   logic                present_ff, present_in;
   logic                exhausted_ff, exhausted_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_present_ff, rsp_present_in;
   logic                rsp_exhausted_ff, rsp_exhausted_in;

   logic                ram_we;
   logic [ADDR_W-1:0]   ram_addr;
   logic [NODE_W-1:0]   ram_wdata;
   logic [NODE_W-1:0]   ram_rdata;
   logic [ADDR_W-1:0]   slot_addr;
   logic [LVL_W-1:0]    needed;
   logic                req_take;
   logic [LETTER_W-1:0] code;

   fwt_link_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (NODE_W)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign slot_addr  = ADDR_W'(node_ff) * ALPHA_A + ADDR_W'(letters_ff[level_ff]);
   assign needed     = LAST_LVL - level_ff;

   always_comb begin
      state_in         = state_ff;
      clr_in           = clr_ff;
      free_in          = free_ff;
      node_in          = node_ff;
      level_in         = level_ff;
      cmd_in           = cmd_ff;
      letters_in       = letters_ff;
      present_in       = present_ff;
      exhausted_in     = exhausted_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_present_in   = rsp_present_ff;
      rsp_exhausted_in = rsp_exhausted_ff;
      ram_we           = 1'b0;
      ram_addr         = slot_addr;
      ram_wdata        = '0;
      code             = '0;

      unique case (state_ff)
         S_CLEAR: begin
            ram_we   = 1'b1;
            ram_addr = clr_ff;
            clr_in   = clr_ff + ADDR_W'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_take) begin
               cmd_in       = cmd_type'(req_tuser);
               node_in      = '0;
               level_in     = '0;
               present_in   = 1'b0;
               exhausted_in = 1'b0;
               for (int i = 0; i < WORD_LENGTH; i++) begin
                  code = '0;
                  if (i < LETTER_FIELDS) begin
                     code = req_tdata[i*LETTER_W +: LETTER_W];
                  end
                  letters_in[i] = ({1'b0, code} >= ALPHA_L) ? SAT_CODE : code;
               end
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (ram_rdata == '0) begin
               if (cmd_ff == CMD_INSERT) begin
                  if ((FREE_W + 1)'(free_ff) + (FREE_W + 1)'(needed) > POOL_TOP) begin
                     exhausted_in = 1'b1;
                     state_in     = S_DONE;
                  end else begin
                     state_in = S_WRITE;
                  end
               end else begin
                  state_in = S_DONE;
               end
            end else if (level_ff == LAST_LVL) begin
               present_in = 1'b1;
               state_in   = S_DONE;
            end else begin
               node_in  = ram_rdata;
               level_in = level_ff + LVL_W'(1);
               state_in = S_ISSUE;
            end
         end
         S_WRITE: begin
            ram_we = 1'b1;
            if (level_ff == LAST_LVL) begin
               ram_wdata = END_MARK;
               state_in  = S_DONE;
            end else begin
               ram_wdata = free_ff[NODE_W-1:0];
               node_in   = free_ff[NODE_W-1:0];
               free_in   = free_ff + FREE_W'(1);
               level_in  = level_ff + LVL_W'(1);
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in     = 1'b1;
               rsp_present_in   = present_ff;
               rsp_exhausted_in = exhausted_ff;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         free_ff      <= FREE_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      node_ff          <= node_in;
      level_ff         <= level_in;
      cmd_ff           <= cmd_in;
      letters_ff       <= letters_in;
      present_ff       <= present_in;
      exhausted_ff     <= exhausted_in;
      rsp_present_ff   <= rsp_present_in;
      rsp_exhausted_ff <= rsp_exhausted_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - 2){1'b0}}, rsp_exhausted_ff, rsp_present_ff};

   // a refused insert never reports the word as present
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("present and pool_exhausted both set");

   // one request in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while busy");

   // allocation never runs past the node pool
   a_pool_bound: assert property (@(posedge clock) disable iff (reset)
      (FREE_W + 1)'(free_ff) <= POOL_TOP && free_ff != '0)
      else $error("free node counter out of range");

   // writes only during the sweep or an insert
   a_write_on_insert: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff != S_CLEAR) |-> (cmd_ff == CMD_INSERT && !exhausted_ff))
      else $error("link write outside an insert");

endmodule

/* design/fwt_link_ram.sv */
// ----------------------------------------------------------------------------
// fwt_link_ram
// Single-port synchronous link memory, one read, or one write with a read
// of the old entry, per cycle, registered read data.
// ----------------------------------------------------------------------------
module fwt_link_ram
   import fwt_pkg::*;
#(
   parameter int DEPTH  = 425984,
   parameter int ADDR_W = 19,
   parameter int DATA_W = 14
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule
